FILE: rtl/phc_pkg.sv
package phc_pkg;

  localparam int MAGIC_LENGTH_DEF    = 8;
  localparam int HEADER_LIMIT_DEF    = 4096;
  localparam int NAME_CAP_DEF        = 64;
  localparam int VERSION_CAP_DEF     = 32;
  localparam int DESCRIPTION_CAP_DEF = 256;

  localparam int LEN_W = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'd1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MAGIC   = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_FIELD   = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;
  localparam logic [2:0] ST_SIZE    = 3'd5;
  localparam logic [2:0] ST_CRC     = 3'd6;

  localparam logic [2:0] KEY_UNDEC   = 3'd0;
  localparam logic [2:0] KEY_NAME    = 3'd1;
  localparam logic [2:0] KEY_VERSION = 3'd2;
  localparam logic [2:0] KEY_DESC    = 3'd3;
  localparam logic [2:0] KEY_SIZE    = 3'd4;
  localparam logic [2:0] KEY_CRC     = 3'd5;
  localparam logic [2:0] KEY_NONE    = 3'd7;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [63:0] num;
    logic        hex;
    logic        fault;
  } num_state_t;

  function automatic logic [3:0] key_len_f(input logic [2:0] k);
    case (k)
      KEY_NAME:    key_len_f = 4'd4;
      KEY_VERSION: key_len_f = 4'd7;
      KEY_DESC:    key_len_f = 4'd11;
      KEY_SIZE:    key_len_f = 4'd4;
      KEY_CRC:     key_len_f = 4'd5;
      default:     key_len_f = 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] key_char_f(input logic [2:0] k, input logic [3:0] i);
    logic [87:0] s;
    s = '0;
    case (k)
      KEY_NAME:    s = {56'd0, "eman"};
      KEY_VERSION: s = {32'd0, "noisrev"};
      KEY_DESC:    s = "noitpircsed";
      KEY_SIZE:    s = {56'd0, "ezis"};
      KEY_CRC:     s = {48'd0, "23crc"};
      default:     s = '0;
    endcase
    key_char_f = (i < 4'd11) ? s[8*i +: 8] : 8'd0;
  endfunction

endpackage

FILE: rtl/phc_if.sv
interface byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_mark;
  modport source (output valid, data_byte, end_mark, input ready);
  modport sink (input valid, data_byte, end_mark, output ready);
endinterface

interface result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] declared_size;
  logic [31:0] declared_crc;
  logic [31:0] computed_crc;
  logic [12:0] payload_offset;
  modport source (output valid, status, declared_size, declared_crc, computed_crc,
                  payload_offset, input ready);
  modport sink (input valid, status, declared_size, declared_crc, computed_crc,
                payload_offset, output ready);
endinterface

interface cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/phc_digit.sv
module phc_digit
  import phc_pkg::*;
(
  input  logic [7:0]       c,
  input  logic [LEN_W-1:0] value_len,
  input  num_state_t       cur,
  output num_state_t       nxt
);

  logic [3:0]  d;
  logic        is_digit;
  logic [67:0] wide;

  always_comb begin
    d = 4'd0;
    is_digit = 1'b1;
    if (c >= "0" && c <= "9") d = 4'(c - "0");
    else if (cur.hex && c >= "a" && c <= "f") d = 4'(c - "a" + 8'd10);
    else if (cur.hex && c >= "A" && c <= "F") d = 4'(c - "A" + 8'd10);
    else is_digit = 1'b0;

    if (cur.hex) wide = {4'd0, cur.num[59:0], d} | {cur.num[63:60], 64'd0};
    else wide = ({4'd0, cur.num} << 3) + ({4'd0, cur.num} << 1) + {64'd0, d};

    nxt = cur;
    if (!cur.fault) begin
      if (value_len == LEN_W'(1) && !cur.hex && cur.num == '0 && (c == "x" || c == "X")) begin
        nxt.hex = 1'b1;
      end else if (!is_digit || wide[67:64] != 4'd0) begin
        nxt.fault = 1'b1;
      end else begin
        nxt.num = wide[63:0];
      end
    end
  end

endmodule

FILE: rtl/package_header_check.sv
// Data path: a byte is registered on acceptance and processed from the input register; the
//   result of an end-marked byte is registered when that byte is processed.
// Throughput: one byte per cycle; the per-byte state update and bytewise CRC run in one pass.
//   An end-marked byte waits in the input register while an earlier result is unaccepted.
// Reset: synchronous, active high; clears parse state, the registers (magic to zero,
//   payload limit to all ones) and the result valid flag.
module package_header_check
  import phc_pkg::*;
#(
  parameter int MAGIC_LENGTH    = MAGIC_LENGTH_DEF,
  parameter int HEADER_LIMIT    = HEADER_LIMIT_DEF,
  parameter int NAME_CAP        = NAME_CAP_DEF,
  parameter int VERSION_CAP     = VERSION_CAP_DEF,
  parameter int DESCRIPTION_CAP = DESCRIPTION_CAP_DEF
)(
  input logic       clk,
  input logic       rst,
  byte_if.sink      src,
  result_if.source  res,
  cfg_if.sink       cfg
);

  typedef enum logic [2:0] {
    PH_MAGIC, PH_LINE, PH_KEY, PH_VFIRST, PH_VALUE, PH_PAYLOAD, PH_DRAIN
  } phase_t;

  localparam logic [31:0] CAP = 32'(HEADER_LIMIT);

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  logic [63:0] magic_bytes;
  logic [31:0] payload_limit;

  logic       in_v;
  logic [7:0] in_b;
  logic       in_last;
  logic       advance;

  phase_t           phase, phase_next;
  logic [31:0]      byte_position, byte_position_next;
  logic [2:0]       key_match, key_match_next;
  logic [LEN_W-1:0] key_length, key_length_next;
  logic [LEN_W-1:0] value_length, value_length_next;
  num_state_t       num, num_next;
  logic [3:0]       seen_fields, seen_fields_next;
  logic [2:0]       pending_error, pending_error_next;
  logic [63:0]      size_register, size_register_next;
  logic [31:0]      crc_register, crc_register_next;
  logic [31:0]      running_crc, running_crc_next;
  logic [31:0]      payload_count, payload_count_next;
  logic [12:0]      payload_start, payload_start_next;

  logic [2:0]  status_next;
  num_state_t  dig_out;
  logic [LEN_W-1:0] kb_len;
  logic [2:0]  kb_match;
  logic [2:0]  line_err;
  logic        number_bad;

  assign advance = in_v && (!in_last || !res.valid || res.ready);
  assign src.ready = !in_v || advance;
  assign cfg.ready = 1'b1;

  phc_digit u_digit (
    .c(in_b), .value_len(value_length), .cur(num), .nxt(dig_out)
  );

  always_comb begin
    // key byte step; a fresh line starts from an empty key
    kb_len = (phase == PH_LINE) ? '0 : key_length;
    kb_match = key_match;
    if (kb_len == '0) begin
      kb_match = KEY_NONE;
      for (int i = 1; i <= 5; i++)
        if (key_char_f(3'(i), 4'd0) == in_b) kb_match = 3'(i);
    end else if (key_match >= KEY_NAME && key_match <= KEY_CRC) begin
      if (kb_len >= LEN_W'(key_len_f(key_match)) ||
          key_char_f(key_match, kb_len[3:0]) != in_b) kb_match = KEY_NONE;
    end

    number_bad = value_length == '0 || num.fault || (num.hex && value_length == LEN_W'(2));
    line_err = ST_OK;
    case (key_match)
      KEY_NAME:    if (value_length == '0 || value_length >= LEN_W'(NAME_CAP))
                     line_err = ST_FIELD;
      KEY_VERSION: if (value_length >= LEN_W'(VERSION_CAP)) line_err = ST_FIELD;
      KEY_DESC:    if (value_length >= LEN_W'(DESCRIPTION_CAP)) line_err = ST_FIELD;
      KEY_SIZE:    if (number_bad) line_err = ST_FIELD;
      KEY_CRC:     if (number_bad || num.num[63:32] != '0) line_err = ST_FIELD;
      default:     line_err = ST_FIELD;
    endcase
  end

  always_comb begin
    phase_next = phase;
    key_match_next = key_match;
    key_length_next = key_length;
    value_length_next = value_length;
    num_next = num;
    seen_fields_next = seen_fields;
    pending_error_next = pending_error;
    size_register_next = size_register;
    crc_register_next = crc_register;
    running_crc_next = running_crc;
    payload_count_next = payload_count;
    payload_start_next = payload_start;

    case (phase)
      PH_MAGIC: begin
        if (byte_position < 32'(MAGIC_LENGTH)) begin
          if (magic_bytes[8*byte_position[2:0] +: 8] != in_b) begin
            pending_error_next = ST_MAGIC;
            phase_next = PH_DRAIN;
          end
        end else if (in_b != CH_NL) begin
          pending_error_next = ST_MAGIC;
          phase_next = PH_DRAIN;
        end else begin
          phase_next = PH_LINE;
        end
      end
      PH_LINE: begin
        if (byte_position > CAP) begin
          pending_error_next = ST_TRUNC;
          phase_next = PH_DRAIN;
        end else if (in_b == CH_NL) begin
          if (seen_fields != 4'hF) begin
            pending_error_next = ST_MISSING;
            phase_next = PH_DRAIN;
          end else if (size_register > {32'd0, payload_limit}) begin
            pending_error_next = ST_SIZE;
            phase_next = PH_DRAIN;
          end else begin
            payload_start_next = 13'(byte_position + 32'd1);
            phase_next = PH_PAYLOAD;
          end
        end else begin
          value_length_next = '0;
          num_next = '0;
          if (in_b == CH_COLON) begin
            key_match_next = KEY_NONE;
            key_length_next = '0;
            phase_next = PH_VFIRST;
          end else begin
            key_match_next = kb_match;
            key_length_next = LEN_W'(1);
            phase_next = PH_KEY;
          end
        end
      end
      PH_KEY, PH_VFIRST, PH_VALUE: begin
        if (byte_position > CAP && !(byte_position == CAP + 32'd1 && in_b == CH_NL)) begin
          pending_error_next = ST_TRUNC;
          phase_next = PH_DRAIN;
        end else if (in_b == CH_NL) begin
          if (phase == PH_KEY || line_err != ST_OK) begin
            pending_error_next = (phase == PH_KEY) ? ST_FIELD : line_err;
            phase_next = PH_DRAIN;
          end else begin
            case (key_match)
              KEY_NAME:    seen_fields_next = seen_fields | 4'b0001;
              KEY_VERSION: seen_fields_next = seen_fields | 4'b0010;
              KEY_SIZE: begin
                seen_fields_next = seen_fields | 4'b0100;
                size_register_next = num.num;
              end
              KEY_CRC: begin
                seen_fields_next = seen_fields | 4'b1000;
                crc_register_next = num.num[31:0];
              end
              default: seen_fields_next = seen_fields;
            endcase
            if (byte_position > CAP) begin
              pending_error_next = ST_TRUNC;
              phase_next = PH_DRAIN;
            end else begin
              phase_next = PH_LINE;
            end
          end
        end else if (phase == PH_KEY) begin
          if (in_b == CH_COLON) begin
            if (!(key_match >= KEY_NAME && key_match <= KEY_CRC &&
                  key_length == LEN_W'(key_len_f(key_match)))) key_match_next = KEY_NONE;
            phase_next = PH_VFIRST;
          end else begin
            key_match_next = kb_match;
            if (key_length != '1) key_length_next = key_length + LEN_W'(1);
          end
        end else begin
          phase_next = PH_VALUE;
          if (phase == PH_VALUE || in_b != CH_SPACE) begin
            num_next = dig_out;
            if (value_length != '1) value_length_next = value_length + LEN_W'(1);
          end
        end
      end
      PH_PAYLOAD: begin
        if ({32'd0, payload_count} < size_register) begin
          running_crc_next = crc_byte(running_crc, in_b);
          payload_count_next = payload_count + 32'd1;
        end
      end
      default: phase_next = phase;
    endcase

    byte_position_next = (byte_position != '1) ? byte_position + 32'd1 : byte_position;

    if (pending_error_next != ST_OK) status_next = pending_error_next;
    else if (phase_next == PH_MAGIC) status_next = ST_MAGIC;
    else if (phase_next == PH_PAYLOAD) begin
      if ({32'd0, payload_count_next} < size_register_next) status_next = ST_SIZE;
      else if (~running_crc_next != crc_register_next) status_next = ST_CRC;
      else status_next = ST_OK;
    end else status_next = ST_TRUNC;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (src.ready) begin
      in_v <= src.valid;
    end
    if (src.ready && src.valid) begin
      in_b <= src.data_byte;
      in_last <= src.end_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_bytes <= '0;
      payload_limit <= '1;
    end else if (cfg.valid) begin
      if (cfg.index == REG_MAGIC) magic_bytes <= cfg.data;
      else if (cfg.index == REG_LIMIT) payload_limit <= cfg.data[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && in_last)) begin
      phase <= PH_MAGIC;
      byte_position <= '0;
      key_match <= KEY_UNDEC;
      key_length <= '0;
      value_length <= '0;
      num <= '0;
      seen_fields <= '0;
      pending_error <= ST_OK;
      size_register <= '0;
      crc_register <= '0;
      running_crc <= '1;
      payload_count <= '0;
      payload_start <= '0;
    end else if (advance) begin
      phase <= phase_next;
      byte_position <= byte_position_next;
      key_match <= key_match_next;
      key_length <= key_length_next;
      value_length <= value_length_next;
      num <= num_next;
      seen_fields <= seen_fields_next;
      pending_error <= pending_error_next;
      size_register <= size_register_next;
      crc_register <= crc_register_next;
      running_crc <= running_crc_next;
      payload_count <= payload_count_next;
      payload_start <= payload_start_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance && in_last) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (advance && in_last) begin
      res.status <= status_next;
      res.declared_size <= (size_register_next[63:32] != '0) ? '1 : size_register_next[31:0];
      res.declared_crc <= crc_register_next;
      res.computed_crc <= (status_next == ST_OK || status_next == ST_CRC) ?
                          ~running_crc_next : '0;
      res.payload_offset <= payload_start_next;
    end
  end

endmodule

FILE: tb/package_header_check_test.sv
`timescale 1ns / 100ps
module package_header_check_test;
  import phc_pkg::*;

  typedef enum logic [2:0] {
    P_MAGIC, P_LINE, P_KEY, P_VFIRST, P_VALUE, P_PAYLOAD, P_DRAIN
  } parse_phase_t;

  typedef enum int {
    F_NONE, F_MAGIC, F_TRUNC, F_KEY, F_MISSING, F_SHORT, F_CRC, F_CAP,
    F_NUMBER, F_NOCOLON, F_REPEAT, F_EXTRA
  } flaw_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkg_byte_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] size;
    logic [31:0] crc;
    logic [31:0] calc;
    logic [12:0] offset;
  } verdict_t;

  localparam int          HDR_CAP = HEADER_LIMIT_DEF;
  localparam logic [12:0] LEN_SAT = 13'h1FFF;
  localparam int          LINE_NAME = 0, LINE_VERSION = 1, LINE_DESC = 2;
  localparam int          LINE_SIZE = 3, LINE_CRC = 4;

  logic clk;
  logic rst;

  byte_if   src_ch ();
  result_if res_ch ();
  cfg_if    cfg_ch ();

  package_header_check u_top (
    .clk (clk),
    .rst (rst),
    .src (src_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  pkg_byte_t  byte_q[$];
  verdict_t   verdict_q[$];
  logic [7:0] pkg[$];

  // register copies and parse state of the predictor
  logic [63:0]  magic_reg;
  logic [31:0]  limit_reg;
  parse_phase_t ph;
  logic [31:0]  bpos;
  logic [2:0]   kmatch;
  logic [12:0]  klen;
  logic [12:0]  vlen;
  logic [63:0]  nval;
  logic         hexb;
  logic         lfault;
  logic [3:0]   seen;
  logic [2:0]   perr;
  logic [63:0]  size_acc;
  logic [31:0]  crc_acc;
  logic [31:0]  run_crc;
  logic [31:0]  pay_cnt;
  logic [12:0]  pay_start;

  int fails = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int pkgs_sent = 0;
  bit took = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit long_hold = 0;
  logic [15:0] stall_pat = '1;
  int pat_age = 0;
  logic [31:0] decl_size;
  logic [31:0] decl_crc;

  function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
    c ^= {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic string key_word(logic [2:0] k);
    case (k)
      KEY_NAME:    return "name";
      KEY_VERSION: return "version";
      KEY_DESC:    return "description";
      KEY_SIZE:    return "size";
      KEY_CRC:     return "crc32";
      default:     return "";
    endcase
  endfunction

  function automatic int key_len_word(logic [2:0] k);
    string w;
    w = key_word(k);
    return w.len();
  endfunction

  function automatic void clear_parse();
    ph = P_MAGIC;
    bpos = 0;
    kmatch = KEY_UNDEC;
    klen = 0;
    vlen = 0;
    nval = 0;
    hexb = 0;
    lfault = 0;
    seen = 0;
    perr = ST_OK;
    size_acc = 0;
    crc_acc = 0;
    run_crc = '1;
    pay_cnt = 0;
    pay_start = 0;
  endfunction

  function automatic void raise(logic [2:0] code);
    perr = code;
    ph = P_DRAIN;
  endfunction

  function automatic void feed_key(logic [7:0] c);
    string w;
    if (klen == 0) begin
      kmatch = KEY_NONE;
      for (int i = 1; i <= 5; i++) begin
        w = key_word(3'(i));
        if (w[0] == c) kmatch = 3'(i);
      end
    end else if (kmatch >= KEY_NAME && kmatch <= KEY_CRC) begin
      w = key_word(kmatch);
      if (klen >= w.len() || w[klen] != c) kmatch = KEY_NONE;
    end
    if (klen < LEN_SAT) klen++;
  endfunction

  function automatic void feed_value(logic [7:0] c);
    logic [63:0] d;
    logic [63:0] base;
    if (vlen < LEN_SAT) vlen++;
    if (lfault) return;
    // lone leading zero followed by x switches to hex
    if (vlen == 2 && !hexb && nval == 0 && (c == "x" || c == "X")) begin
      hexb = 1;
      return;
    end
    if (c >= "0" && c <= "9") d = 64'(c - "0");
    else if (hexb && c >= "a" && c <= "f") d = 64'(c - "a" + 10);
    else if (hexb && c >= "A" && c <= "F") d = 64'(c - "A" + 10);
    else begin
      lfault = 1;
      return;
    end
    base = hexb ? 64'd16 : 64'd10;
    if (nval > (64'hFFFF_FFFF_FFFF_FFFF - d) / base) begin
      lfault = 1;
      return;
    end
    nval = nval * base + d;
  endfunction

  function automatic logic [2:0] line_verdict();
    logic nbad;
    nbad = (vlen == 0) || lfault || (hexb && vlen == 2);
    case (kmatch)
      KEY_NAME: begin
        if (vlen == 0 || vlen >= NAME_CAP_DEF) return ST_FIELD;
        seen[0] = 1;
      end
      KEY_VERSION: begin
        if (vlen >= VERSION_CAP_DEF) return ST_FIELD;
        seen[1] = 1;
      end
      KEY_DESC: begin
        if (vlen >= DESCRIPTION_CAP_DEF) return ST_FIELD;
      end
      KEY_SIZE: begin
        if (nbad) return ST_FIELD;
        size_acc = nval;
        seen[2] = 1;
      end
      KEY_CRC: begin
        if (nbad || nval > 64'hFFFF_FFFF) return ST_FIELD;
        crc_acc = nval[31:0];
        seen[3] = 1;
      end
      default: return ST_FIELD;
    endcase
    return ST_OK;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    logic [2:0] err;
    verdict_t v;
    case (ph)
      P_MAGIC: begin
        if (bpos < MAGIC_LENGTH_DEF) begin
          if (magic_reg[8*bpos[2:0] +: 8] != b) raise(ST_MAGIC);
        end else if (b != CH_NL) raise(ST_MAGIC);
        else ph = P_LINE;
      end
      P_LINE: begin
        if (bpos > HDR_CAP) raise(ST_TRUNC);
        else if (b == CH_NL) begin
          if (seen != 4'hF) raise(ST_MISSING);
          else if (size_acc > {32'd0, limit_reg}) raise(ST_SIZE);
          else begin
            pay_start = 13'(bpos + 1);
            ph = P_PAYLOAD;
          end
        end else begin
          kmatch = KEY_UNDEC;
          klen = 0;
          vlen = 0;
          nval = 0;
          hexb = 0;
          lfault = 0;
          ph = P_KEY;
          if (b == CH_COLON) begin
            kmatch = KEY_NONE;
            ph = P_VFIRST;
          end else feed_key(b);
        end
      end
      P_KEY, P_VFIRST, P_VALUE: begin
        // a newline right past the cap still gets its line checked first
        if (bpos > HDR_CAP && !(bpos == HDR_CAP + 1 && b == CH_NL)) raise(ST_TRUNC);
        else if (b == CH_NL) begin
          err = (ph == P_KEY) ? ST_FIELD : line_verdict();
          if (err != ST_OK) raise(err);
          else if (bpos > HDR_CAP) raise(ST_TRUNC);
          else ph = P_LINE;
        end else if (ph == P_KEY) begin
          if (b == CH_COLON) begin
            if (!(kmatch >= KEY_NAME && kmatch <= KEY_CRC && klen == key_len_word(kmatch)))
              kmatch = KEY_NONE;
            ph = P_VFIRST;
          end else feed_key(b);
        end else if (ph == P_VFIRST) begin
          ph = P_VALUE;
          if (b != CH_SPACE) feed_value(b);
        end else feed_value(b);
      end
      P_PAYLOAD: begin
        if ({32'd0, pay_cnt} < size_acc) begin
          run_crc = crc_next(run_crc, b);
          pay_cnt++;
        end
      end
      default: ;
    endcase
    if (bpos != 32'hFFFF_FFFF) bpos++;
    if (!last) return;
    if (perr != ST_OK) v.status = perr;
    else if (ph == P_MAGIC) v.status = ST_MAGIC;
    else if (ph == P_PAYLOAD) begin
      if ({32'd0, pay_cnt} < size_acc) v.status = ST_SIZE;
      else if (~run_crc != crc_acc) v.status = ST_CRC;
      else v.status = ST_OK;
    end else v.status = ST_TRUNC;
    v.size = (size_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : size_acc[31:0];
    v.crc = crc_acc;
    v.calc = (v.status == ST_OK || v.status == ST_CRC) ? ~run_crc : 32'd0;
    v.offset = pay_start;
    verdict_q.push_back(v);
    clear_parse();
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Timeout with %0d results still pending", verdict_q.size());
    $display("Regression FAIL");
    $finish;
  end

  // sender: bursts of random length, random gaps between them
  always @(negedge clk) begin
    bit free;
    free = took || !src_ch.valid;
    if (took) begin
      void'(byte_q.pop_front());
      took = 0;
    end
    if (free) begin
      if (gap_left > 0) begin
        gap_left--;
        src_ch.valid <= 0;
      end else if (byte_q.size() > 0) begin
        src_ch.valid <= 1;
        src_ch.data_byte <= byte_q[0].data;
        src_ch.end_mark <= byte_q[0].last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 7);
        end else burst_left--;
      end else src_ch.valid <= 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && src_ch.valid && src_ch.ready) begin
      predict_byte(src_ch.data_byte, src_ch.end_mark);
      took = 1;
    end
  end

  // receiver stall pattern, rotated and redrawn now and then
  always @(negedge clk) begin
    if (pat_age == 0) begin
      pat_age = $urandom_range(20, 80);
      case ($urandom_range(2))
        0: stall_pat = '1;
        1: stall_pat = 16'($urandom);
        default: stall_pat = 16'($urandom | $urandom);
      endcase
    end
    pat_age--;
    stall_pat = {stall_pat[14:0], stall_pat[15]};
    res_ch.ready <= !long_hold && stall_pat[0];
  end

  initial begin
    wait (results_seen >= 8);
    @(negedge clk);
    long_hold = 1;
    repeat (400) @(posedge clk);
    long_hold = 0;
  end

  task automatic report(string what, verdict_t want, verdict_t got);
    fails++;
    if (fails <= 10)
      $display("%s: status %0d/%0d size %h/%h crc %h/%h calc %h/%h offset %0d/%0d (exp/act)",
               what, want.status, got.status, want.size, got.size, want.crc, got.crc,
               want.calc, got.calc, want.offset, got.offset);
  endtask

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.status, res_ch.declared_size, res_ch.declared_crc,
              res_ch.computed_crc, res_ch.payload_offset};
      results_seen++;
      if (verdict_q.size() == 0) report("Unexpected result", got, got);
      else begin
        want = verdict_q.pop_front();
        if (got.status !== want.status || got.size !== want.size || got.crc !== want.crc ||
            got.calc !== want.calc || got.offset !== want.offset)
          report("Mismatch", want, got);
      end
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) pkg.push_back(s[i]);
  endtask

  task automatic add_rand_text(int n);
    for (int i = 0; i < n; i++) pkg.push_back(8'($urandom_range(32, 255)));
  endtask

  function automatic string num_text(logic [63:0] v);
    string s;
    case ($urandom_range(3))
      0: s = $sformatf("%0d", v);
      1: s = {"0x", $sformatf("%0h", v)};
      2: begin
        s = $sformatf("%0h", v);
        s = {"0X", s.toupper()};
      end
      default: s = {"0", $sformatf("%0d", v)};
    endcase
    return s;
  endfunction

  task automatic add_number_flaw(int kind);
    case ($urandom_range(7))
      0: ;
      1: add_text("0x");
      2: add_text("12g4");
      3: add_text("0x1G");
      4: add_text("99999999999999999999");
      5: add_text("0x10000000000000000");
      6: add_text(" 5");
      default: add_text(kind == LINE_CRC ? "0x100000000" : "0x100000000");
    endcase
  endtask

  task automatic emit_line(int code);
    int kind;
    int fl;
    int n;
    kind = code & 15;
    fl = code >> 4;
    if (fl == F_NOCOLON) begin
      case ($urandom_range(2))
        0: add_text("name value");
        1: add_text(": x");
        default: add_text("name:");
      endcase
      pkg.push_back(CH_NL);
      return;
    end
    if (fl == F_KEY) begin
      case ($urandom_range(4))
        0: add_text("nam");
        1: add_text("names");
        2: add_text("Size");
        3: add_text("crc3");
        default: add_text("vers1on");
      endcase
    end else add_text(key_word(3'(kind + 1)));
    add_text(($urandom_range(3) == 0) ? ":" : ": ");
    case (kind)
      LINE_NAME: begin
        n = (fl == F_CAP) ? NAME_CAP_DEF : ($urandom_range(7) == 0 ? NAME_CAP_DEF - 1
                                           : $urandom_range(1, 8));
        add_rand_text(n);
      end
      LINE_VERSION: begin
        n = (fl == F_CAP) ? VERSION_CAP_DEF : ($urandom_range(7) == 0 ? VERSION_CAP_DEF - 1
                                              : $urandom_range(0, 6));
        add_rand_text(n);
      end
      LINE_DESC: begin
        n = (fl == F_CAP) ? DESCRIPTION_CAP_DEF
          : ($urandom_range(9) == 0 ? DESCRIPTION_CAP_DEF - 1 : $urandom_range(0, 20));
        add_rand_text(n);
      end
      LINE_SIZE: begin
        if (fl == F_NUMBER) add_number_flaw(kind);
        else add_text(num_text({32'd0, decl_size}));
      end
      default: begin
        if (fl == F_NUMBER) add_number_flaw(kind);
        else add_text(num_text({32'd0, decl_crc}));
      end
    endcase
    pkg.push_back(CH_NL);
  endtask

  task automatic add_magic();
    for (int i = 0; i < MAGIC_LENGTH_DEF; i++) pkg.push_back(magic_reg[8*i +: 8]);
    pkg.push_back(CH_NL);
  endtask

  task automatic send_package();
    for (int i = 0; i < pkg.size(); i++) byte_q.push_back('{pkg[i], i == pkg.size() - 1});
    bytes_sent += pkg.size();
    pkgs_sent++;
  endtask

  task automatic build_package(int flaw);
    logic [7:0] body[$];
    logic [31:0] c;
    int lines[$];
    int n, j, t;
    n = ($urandom_range(4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    c = '1;
    for (int i = 0; i < n; i++) begin
      body.push_back(8'($urandom));
      c = crc_next(c, body[i]);
    end
    decl_size = n;
    decl_crc = (flaw == F_CRC) ? (~c ^ (32'd1 << $urandom_range(31))) : ~c;
    pkg.delete();
    add_magic();
    if (flaw == F_MAGIC) begin
      j = $urandom_range(MAGIC_LENGTH_DEF);
      pkg[j] = pkg[j] ^ 8'(1 << $urandom_range(7));
    end
    lines = '{LINE_NAME, LINE_VERSION, LINE_SIZE, LINE_CRC};
    if ($urandom_range(1)) lines.push_back(LINE_DESC);
    if (flaw == F_MISSING) lines.delete($urandom_range(3));
    if (flaw == F_REPEAT) lines.push_back($urandom_range(4));
    case (flaw)
      F_KEY, F_NOCOLON: lines.push_back(LINE_NAME | (flaw << 4));
      F_CAP: lines.push_back($urandom_range(2) | (flaw << 4));
      F_NUMBER: lines.push_back($urandom_range(LINE_SIZE, LINE_CRC) | (flaw << 4));
      default: ;
    endcase
    for (int i = lines.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = lines[i];
      lines[i] = lines[j];
      lines[j] = t;
    end
    foreach (lines[i]) emit_line(lines[i]);
    pkg.push_back(CH_NL);
    if (flaw == F_SHORT && n > 0) n = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) pkg.push_back(body[i]);
    if (flaw == F_EXTRA) add_rand_text($urandom_range(1, 5));
    if (flaw == F_TRUNC) while (pkg.size() > 1 && $urandom_range(9) != 0)
      void'(pkg.pop_back());
    if (pkg.size() == 0) pkg.push_back(8'($urandom));
    send_package();
  endtask

  // header grown with description lines so that a newline lands just past the cap
  task automatic build_long(int over);
    int n;
    pkg.delete();
    decl_size = 0;
    decl_crc = 0;
    add_magic();
    for (int k = LINE_NAME; k <= LINE_CRC; k++) emit_line(k);
    while (HDR_CAP - 12 - pkg.size() >= 256) begin
      add_text("description: ");
      add_rand_text(200);
      pkg.push_back(CH_NL);
    end
    n = HDR_CAP - 12 - pkg.size() + over;
    add_text("description: ");
    add_rand_text(n);
    pkg.push_back(CH_NL);
    pkg.push_back(CH_NL);
    send_package();
  endtask

  task automatic set_reg(logic [0:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_MAGIC) magic_reg = value;
    else limit_reg = value[31:0];
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || src_ch.valid || verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_random(int goal);
    int b0, p0, r;
    b0 = bytes_sent;
    p0 = pkgs_sent;
    while (bytes_sent - b0 < goal || pkgs_sent - p0 < 12) begin
      r = $urandom_range(11);
      if (r == 0) begin
        pkg.delete();
        add_rand_text(0);
        for (int i = $urandom_range(1, 12); i > 0; i--) pkg.push_back(8'($urandom));
        send_package();
      end else if (r <= 4) build_package(r == 1 ? F_EXTRA : (r == 2 ? F_REPEAT : F_NONE));
      else build_package($urandom_range(F_MAGIC, F_EXTRA));
    end
  endtask

  initial begin
    rst = 1;
    src_ch.valid = 0;
    src_ch.data_byte = 0;
    src_ch.end_mark = 0;
    res_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = REG_MAGIC;
    cfg_ch.data = 0;
    magic_reg = 0;
    limit_reg = '1;
    clear_parse();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed packages under the reset register values
    pkg = '{8'h00};
    send_package();
    pkg.delete();
    add_magic();
    send_package();
    build_long(0);
    build_long(1);
    for (int f = F_NONE; f <= F_EXTRA; f++) build_package(f);
    wait_idle();

    set_reg(REG_MAGIC, {$urandom, $urandom});
    set_reg(REG_LIMIT, '1);
    run_random(360);
    wait_idle();

    set_reg(REG_MAGIC, '1);
    set_reg(REG_LIMIT, 64'd0);
    run_random(360);
    wait_idle();

    set_reg(REG_MAGIC, {$urandom, $urandom});
    set_reg(REG_LIMIT, {32'($urandom), 32'($urandom_range(20))});
    run_random(360);
    wait_idle();

    set_reg(REG_MAGIC, 64'h0102_0408_1020_4080);
    set_reg(REG_LIMIT, {32'($urandom), 32'hFFFF_FFFF});
    run_random(360);
    wait_idle();
    repeat (10) @(posedge clk);

    fails += verdict_q.size();
    $display("Checked %0d results from %0d packages, %0d bytes, over five register settings",
             results_seen, pkgs_sent, bytes_sent);
    $display("Mismatches: %0d", fails);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/phc_pkg.sv
rtl/phc_if.sv
rtl/phc_digit.sv
rtl/package_header_check.sv
tb/package_header_check_test.sv
